// ===== hw/rtl/dmda_pkg.sv =====
package dmda_pkg;

    // payload and register widths
    localparam int SAMPLE_W   = 16;
    localparam int CC_W       = 4;
    localparam int DR_W       = 5;
    localparam int PROD_W     = CC_W + DR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // hard ceiling on the group size
    localparam int GROUP_CAP = 256;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION_RATIO = 2'd1;

    // register reset values
    localparam logic [CC_W-1:0] CC_RESET = 4'd2;
    localparam logic [DR_W-1:0] DR_RESET = 5'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ===== hw/rtl/dmda_fifo.sv =====
module dmda_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    assign full   = (cnt_reg == CNT_W'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rdata  = mem_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("fifo written while full");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("fifo fill count beyond depth");
`endif

endmodule

// ===== hw/rtl/dmda_front.sv =====
module dmda_front #(
    parameter int LIMIT = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dmda_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [dmda_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    input  dmda_pkg::sample_t                 sample,
    input  logic                              job_full,
    output logic                              job_push,
    output logic [dmda_pkg::SAMPLE_W+$clog2(LIMIT)+$clog2(LIMIT+1)-1:0] job_data
);
    import dmda_pkg::*;

    localparam int CNT_W = $clog2(LIMIT + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(LIMIT);

    logic [CC_W-1:0]         cc_reg;
    logic [DR_W-1:0]         dr_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;

    logic [PROD_W-1:0]       prod;
    logic [CNT_W-1:0]        grp_n;
    logic signed [SUM_W-1:0] sum_add;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    accept;
    logic                    grp_done;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= CC_RESET;
            dr_reg <= DR_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_CHANNEL_COUNT)
            begin
                cc_reg <= cfg_data[CC_W-1:0];
            end
            else if (cfg_idx == REG_DECIMATION_RATIO)
            begin
                dr_reg <= cfg_data[DR_W-1:0];
            end
        end
    end

    // group size, clamped to the limit
    always_comb
    begin
        prod  = PROD_W'(cc_reg) * PROD_W'(dr_reg);
        grp_n = (prod > PROD_W'(LIMIT)) ? CNT_W'(LIMIT) : prod[CNT_W-1:0];
    end

    // accumulate and detect group end
    always_comb
    begin
        accept    = push && !job_full;
        sum_add   = sum_reg + SUM_W'(sample);
        cnt_inc   = fill_reg + 1'b1;
        grp_done  = accept && (grp_n != '0) && (cnt_inc >= grp_n);
        sum_next  = sum_reg;
        fill_next = fill_reg;
        if (accept && (grp_n != '0))
        begin
            if (grp_done)
            begin
                sum_next  = '0;
                fill_next = '0;
            end
            else
            begin
                sum_next  = sum_add;
                fill_next = cnt_inc;
            end
        end
    end

    assign job_push = grp_done;
    assign job_data = {sum_add, cnt_inc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CNT_W'(LIMIT))
        else $error("group fill reached the group limit without completing");
`endif

endmodule

// ===== hw/rtl/dmda_divider.sv =====
module dmda_divider #(
    parameter int SUM_W = 23,
    parameter int CNT_W = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_empty,
    input  logic [SUM_W+CNT_W-1:0]          job_data,
    output logic                            job_pop,
    input  logic                            res_full,
    output logic                            res_push,
    output dmda_pkg::sample_t               res_data
);
    import dmda_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;

    logic signed [SUM_W-1:0] job_sum;
    logic [CNT_W-1:0]        job_cnt;
    logic [CNT_W:0]          trial;
    logic [CNT_W:0]          trial_sub;
    logic                    ge;
    logic [SUM_W-1:0]        quo_signed;

    assign job_sum = job_data[SUM_W+CNT_W-1:CNT_W];
    assign job_cnt = job_data[CNT_W-1:0];

    // one restoring step per cycle
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[SUM_W-1]};
        trial_sub = trial - {1'b0, div_reg};
        ge        = (trial >= {1'b0, div_reg});
    end

    // sign fix-up of the quotient magnitude
    assign quo_signed = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;
    assign res_data   = quo_signed[SAMPLE_W-1:0];

    assign job_pop  = (state_reg == ST_IDLE) && !job_empty;
    assign res_push = (state_reg == ST_DONE) && !res_full;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    neg_next   = job_sum[SUM_W-1];
                    dvd_next   = job_sum[SUM_W-1] ? (~job_sum + 1'b1) : job_sum;
                    div_next   = job_cnt;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                rem_next  = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
                dvd_next  = {dvd_reg[SUM_W-2:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

`ifndef ASSERT_OFF
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (rem_reg < div_reg))
        else $error("partial remainder not below divisor");
`endif

endmodule

// ===== hw/rtl/downmix_decimating_averager.sv =====
// a group's last sample transfer pushes its sum and count into the job queue, and the divider
//   then divides the SUM_W-bit sum (SUM_W = 16 + clog2 of the group limit, 23 at the default limit of 128)
// throughput: one sample per cycle into the accumulator while the 2-entry job queue has
//   room, input stalls while it is full; the one-bit-per-cycle divider takes no new job
//   until its result is pushed into the result queue
// reset: rst_n asynchronous, clears sum, fill, queues and divider control;
//   channel_count resets to 2 and decimation_ratio to 3
module downmix_decimating_averager #(
    parameter int MAX_GROUP = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dmda_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [dmda_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    output logic                            full,
    input  dmda_pkg::sample_t               sample,
    output logic                            empty,
    input  logic                            pop,
    output dmda_pkg::sample_t               mixed_sample
);
    import dmda_pkg::*;

    localparam int LIMIT = (MAX_GROUP > GROUP_CAP) ? GROUP_CAP :
                           ((MAX_GROUP < 1) ? 1 : MAX_GROUP);
    localparam int CNT_W = $clog2(LIMIT + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(LIMIT);
    localparam int JOB_W = SUM_W + CNT_W;

    logic             job_push;
    logic [JOB_W-1:0] job_wdata;
    logic             job_full;
    logic             job_pop;
    logic [JOB_W-1:0] job_rdata;
    logic             job_empty;
    logic             res_push;
    sample_t          res_data;
    logic             res_full;

    assign full = job_full;

    // accumulator front
    dmda_front #(
        .LIMIT (LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .push     (push),
        .sample   (sample),
        .job_full (job_full),
        .job_push (job_push),
        .job_data (job_wdata)
    );

    // group sums waiting for division
    dmda_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_wdata),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_rdata),
        .empty (job_empty)
    );

    // averaging divider back
    dmda_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_data  (job_rdata),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // finished averages awaiting transfer
    dmda_fifo #(
        .WIDTH (SAMPLE_W),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (mixed_sample),
        .empty (empty)
    );

endmodule

// ===== tb/sv/downmix_decimating_averager_tb.sv =====
module downmix_decimating_averager_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dmda_pkg::*;

    localparam int MAX_GROUP_TB  = 128;
    localparam int TARGET_ITEMS  = 1450;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;

    // index with no register behind it, writes to it are ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        sample_t                 smp;
        logic                    chk;
        sample_t                 want;
    } row_t;

    // directed stimulus, typed expectations only where obvious
    localparam int N_ROWS = 29;
    localparam row_t DIR_ROWS [0:N_ROWS-1] = '{
        // reset group of six, full-scale positive
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh7FFF, 1'b1, 16'sh7FFF},
        // pairs: full-scale negative, then truncation toward zero
        '{ROW_CFG, REG_DECIMATION_RATIO, 5'd1, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh8000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh8000, 1'b1, 16'sh8000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'shFFFF, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh0000, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh0003, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh0000, 1'b1, 16'sh0001},
        // zero group size, samples ignored
        '{ROW_CFG, REG_CHANNEL_COUNT, 5'd0, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh3039, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'shFFF9, 1'b0, 16'sh0000},
        '{ROW_CFG, REG_CHANNEL_COUNT, 5'd1, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh1234, 1'b1, 16'sh1234},
        // oversized group, then shrunk mid-group
        '{ROW_CFG, REG_CHANNEL_COUNT, 5'h1F, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_CFG, REG_DECIMATION_RATIO, 5'd31, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh8000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh0064, 1'b0, 16'sh0000},
        '{ROW_CFG, REG_DECIMATION_RATIO, 5'd1, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_CFG, REG_CHANNEL_COUNT, 5'd1, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 2'd0, 5'd0, 16'sh0007, 1'b0, 16'sh0000},
        // unused index, then back to the reset setting
        '{ROW_CFG, REG_UNUSED, 5'h1F, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_CFG, REG_CHANNEL_COUNT, 5'd2, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_CFG, REG_DECIMATION_RATIO, 5'd3, 16'sh0000, 1'b0, 16'sh0000}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    sample_t                sample = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    sample_t                mixed_sample;

    // predictor state
    logic [CC_W-1:0]        cc_q = CC_RESET;
    logic [DR_W-1:0]        dr_q = DR_RESET;
    int                     grp_sum = 0;
    logic [7:0]             grp_fill = '0;

    sample_t                avg_q [$];
    int                     err_count = 0;
    int                     cyc = 0;
    int                     rx_cyc = 0;
    int                     burst_left = 0;

    downmix_decimating_averager #(
        .MAX_GROUP (MAX_GROUP_TB)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .sample       (sample),
        .empty        (empty),
        .pop          (pop),
        .mixed_sample (mixed_sample)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at cycle %0d: %s", cyc, what);
        err_count++;
    endtask

    // samples per group, saturated at the group limit
    function automatic int group_len();
        int lim;
        int n;
        lim = MAX_GROUP_TB;
        if (lim > GROUP_CAP)
            lim = GROUP_CAP;
        if (lim < 1)
            lim = 1;
        n = int'(cc_q) * int'(dr_q);
        if (n > lim)
            n = lim;
        return n;
    endfunction

    // accumulate one sample, returns 1 when a group average falls out
    function automatic bit mix_step(input sample_t s, output sample_t avg);
        int n;
        int count;
        int q;
        avg = '0;
        n = group_len();
        if (n == 0)
            return 1'b0;
        grp_sum += int'(s);
        grp_fill = grp_fill + 8'd1;
        count = (grp_fill == 8'd0) ? 256 : int'(grp_fill);
        if (count < n)
            return 1'b0;
        q = grp_sum / count;
        avg = sample_t'(q);
        grp_sum = 0;
        grp_fill = '0;
        return 1'b1;
    endfunction

    // one register write, called at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_CHANNEL_COUNT:    cc_q = data[CC_W-1:0];
            REG_DECIMATION_RATIO: dr_q = data[DR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // hold off until every expected average has come, then let the pipe empty
    task automatic wait_idle();
        push <= 1'b0;
        while (avg_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // one input transfer in bursts with random gaps
    task automatic drive_item(input sample_t v, input logic typed, input sample_t want);
        int      gap;
        sample_t avg;
        bit      got;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push   <= 1'b1;
        sample <= v;
        do
            @(posedge clk);
        while (full);
        got = mix_step(v, avg);
        if (typed)
            avg_q.push_back(want);
        else if (got)
            avg_q.push_back(avg);
        @(negedge clk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return sample_t'($urandom_range(0, 15)) - 16'sd8;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // receiver stall pattern, steps through four characters in turn
    always @(negedge clk)
    begin
        rx_cyc++;
        case ((rx_cyc / 256) % 4)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ((rx_cyc % 16) < 5);
            default: pop <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // result check against the oldest expected average
    always @(posedge clk)
    begin : result_check
        sample_t want;
        if (rst_n && pop && !empty)
        begin
            if (avg_q.size() == 0)
                report_mismatch($sformatf("unexpected result %0d", mixed_sample));
            else
            begin
                want = avg_q.pop_front();
                if (mixed_sample !== want)
                    report_mismatch($sformatf("mixed_sample %0d, wanted %0d",
                                              mixed_sample, want));
            end
        end
    end

    initial
    begin : stimulus
        int         phase;
        int         fed;
        int         nsz;
        int         items;
        logic [CC_W-1:0] cc_new;
        logic [DR_W-1:0] dr_new;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++)
        begin
            if (DIR_ROWS[r].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
            end
            else
                drive_item(DIR_ROWS[r].smp, DIR_ROWS[r].chk, DIR_ROWS[r].want);
        end

        // random phases, each under its own setting
        fed   = 0;
        phase = 0;
        while (fed < TARGET_ITEMS)
        begin
            case (phase)
                0: begin cc_new = 4'd8;  dr_new = 5'd16; end
                1: begin cc_new = 4'd9;  dr_new = 5'd16; end
                2: begin cc_new = 4'd1;  dr_new = 5'd1;  end
                3: begin cc_new = 4'd15; dr_new = 5'd31; end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       cc_new = 4'd0;
                        1:       cc_new = 4'd15;
                        2:       cc_new = 4'd8;
                        default: cc_new = 4'($urandom_range(1, 4));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       dr_new = 5'd0;
                        1:       dr_new = 5'd31;
                        2:       dr_new = 5'd16;
                        default: dr_new = 5'($urandom_range(1, 4));
                    endcase
                end
            endcase

            // registers change only with nothing in flight, group may be part-filled
            wait_idle();
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_CHANNEL_COUNT, {1'($urandom), cc_new});
                write_reg(REG_DECIMATION_RATIO, dr_new);
            end
            else
            begin
                write_reg(REG_DECIMATION_RATIO, dr_new);
                if (phase < 4 || $urandom_range(0, 3) != 0)
                    write_reg(REG_CHANNEL_COUNT, {1'($urandom), cc_new});
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(2'($urandom_range(2, 3)), 5'($urandom));

            nsz = group_len();
            if (nsz == 0)
                items = $urandom_range(3, 8);
            else if (nsz > 32)
                items = $urandom_range(nsz / 2, 2 * nsz);
            else
                items = $urandom_range(8, 60);

            for (int i = 0; i < items; i++)
                drive_item(pick_sample(), 1'b0, 16'sh0000);

            if (nsz != 0)
                fed += items;
            phase++;
        end

        // let everything come out, then a little longer for strays
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (avg_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never came", avg_q.size()));

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
